// ===== rtl/fcdsm_pkg.sv =====
package fcdsm_pkg;

   localparam int STORE_ADDR_BITS = 19;
   localparam int CHANNELS        = 4;
   localparam int CH_BITS         = 2;
   localparam int NUM_BITS        = 38;
   localparam int CNT_BITS        = 6;
   localparam int PROD_BITS       = 34;
   localparam int RATE_BITS       = 18;
   localparam int SUM_BITS        = 19;

   localparam logic [NUM_BITS-1:0] STEP_NUMERATOR = 38'd262144000000;
   localparam logic [17:0]         RATE_RESET     = 18'd44100;
   localparam logic [7:0]          SAMPLE_BIAS    = 8'h80;
   localparam logic [7:0]          READ_IDLE      = 8'hFF;
   localparam logic [31:0]         STEP_SAT       = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_LOAD  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      UNIT_DMA    = 2'd0,
      UNIT_TIMER  = 2'd1,
      UNIT_VOLUME = 2'd2,
      UNIT_MAPPER = 2'd3
   } unit_type;

   localparam logic [3:0] DMA_STATUS  = 4'h8;
   localparam logic [3:0] DMA_CONTROL = 4'hA;
   localparam logic [3:0] DMA_LOOP    = 4'hB;
   localparam logic [3:0] DMA_IGNORED = 4'hD;

   typedef struct packed {
      logic               latch;
      logic               exec;
      logic               mul;
      logic               div_step;
      logic               step_wr;
      logic               fetch;
      logic               mix;
      logic               wrap;
      logic               load_rsp;
      logic [CH_BITS-1:0] ch;
   } ctrl_cmd_type;

   typedef struct packed {
      logic                is_tick;
      logic                need_div;
      logic [CHANNELS-1:0] active;
      logic                div_last;
      logic                rsp_free;
   } dp_status_type;

endpackage

// ===== rtl/fcdsm_ctrl.sv =====
module fcdsm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fcdsm_pkg::dp_status_type status,
   output fcdsm_pkg::ctrl_cmd_type  cmd
);
   import fcdsm_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_EXEC   = 9'b000000010,
      S_MUL    = 9'b000000100,
      S_DIV    = 9'b000001000,
      S_STEPWR = 9'b000010000,
      S_ADDR   = 9'b000100000,
      S_MIX    = 9'b001000000,
      S_WRAP   = 9'b010000000,
      S_FINISH = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CH_BITS-1:0] ch_ff, ch_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      cmd      = '0;
      cmd.ch   = ch_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            ch_in    = '0;
            priority if (status.is_tick) state_in = S_ADDR;
            else if (status.need_div)    state_in = S_MUL;
            else                         state_in = S_FINISH;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_STEPWR;
         end
         S_STEPWR: begin
            cmd.step_wr = 1'b1;
            state_in    = S_FINISH;
         end
         S_ADDR: begin
            // skip silent channels
            if (status.active[ch_ff]) begin
               cmd.fetch = 1'b1;
               state_in  = S_MIX;
            end else if (ch_ff == CH_BITS'(CHANNELS-1)) begin
               state_in = S_FINISH;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
         S_MIX: begin
            cmd.mix  = 1'b1;
            state_in = S_WRAP;
         end
         S_WRAP: begin
            cmd.wrap = 1'b1;
            if (ch_ff == CH_BITS'(CHANNELS-1)) begin
               state_in = S_FINISH;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = S_ADDR;
            end
         end
         S_FINISH: begin
            // hold until the output slot frees
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ch_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
      end
   end

endmodule

// ===== rtl/fcdsm_dpath.sv =====
module fcdsm_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  fcdsm_pkg::ctrl_cmd_type  cmd,
   output fcdsm_pkg::dp_status_type status,
   input  logic [1:0]               req_command,
   input  logic [1:0]               req_port_unit,
   input  logic [7:0]               req_port_low,
   input  logic [7:0]               req_write_data,
   input  logic [18:0]              req_load_address,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [17:0]              csr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_read_data,
   output logic signed [16:0]       rsp_sample_out,
   output logic                     rsp_nmi_pulse
);
   import fcdsm_pkg::*;

   logic [1:0]  cmd_ff;
   logic [1:0]  unit_ff;
   logic [7:0]  low_ff;
   logic [7:0]  data_ff;
   logic [18:0] laddr_ff;

   logic [RATE_BITS-1:0] rate_ff;
   logic [31:0] begin_ff [CHANNELS];
   logic [31:0] len_ff   [CHANNELS];
   logic [31:0] ptr_ff   [CHANNELS];
   logic [31:0] end_ff   [CHANNELS];
   logic [31:0] step_ff  [CHANNELS];
   logic [15:0] timer_ff [CHANNELS];
   logic [7:0]  vol_ff   [CHANNELS];
   logic [CHANNELS-1:0] loop_ff;
   logic [4:0]  page_ff  [16];
   logic [CHANNELS-1:0] mask_ff;
   logic [CHANNELS-1:0] done_ff;

   logic [7:0] store [2**STORE_ADDR_BITS];
   logic [7:0] rd_byte_ff;

   logic [CH_BITS-1:0]   tch_ff;
   logic [PROD_BITS-1:0] prod_ff;
   logic [PROD_BITS-1:0] rem_ff;
   logic [NUM_BITS-1:0]  quo_ff;
   logic [CNT_BITS-1:0]  cnt_ff;

   logic signed [SUM_BITS-1:0] sum_ff;
   logic [31:0] ptr_next_ff;
   logic        nmi_ff;
   logic [7:0]  rd_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_read_ff;
   logic signed [16:0] rsp_sample_ff;
   logic        rsp_nmi_ff;

   // timer write channel decode
   logic [CH_BITS-1:0] t_ch;
   logic               t_ok;
   always_comb begin
      t_ch = low_ff[1:0];
      t_ok = 1'b1;
      if (!low_ff[2] && (low_ff[1:0] == 2'd3)) t_ok = 1'b0;
      if (!low_ff[3]) begin
         if (low_ff[1:0] != 2'd0) t_ok = 1'b0;
         t_ch = 2'd3;
      end
   end

   // fetch address
   logic [15:0]                p_hi;
   logic [18:0]                full_addr;
   logic [STORE_ADDR_BITS-1:0] mem_addr;
   always_comb begin
      p_hi      = ptr_ff[cmd.ch][31:16];
      full_addr = {page_ff[{cmd.ch, p_hi[15:14]}], p_hi[13:0]};
      mem_addr  = cmd.fetch ? full_addr[STORE_ADDR_BITS-1:0]
                            : laddr_ff[STORE_ADDR_BITS-1:0];
   end

   logic mem_we;
   assign mem_we = cmd.exec && (command_type'(cmd_ff) == CMD_LOAD);

   always_ff @(posedge clock) begin
      if (mem_we) store[mem_addr] <= data_ff;
      rd_byte_ff <= store[mem_addr];
   end

   // divider step
   logic [CNT_BITS-1:0]  bit_idx;
   logic [PROD_BITS:0]   trial;
   logic                 fits;
   assign bit_idx = CNT_BITS'(NUM_BITS-1) - cnt_ff;
   assign trial   = {rem_ff, STEP_NUMERATOR[bit_idx]};
   assign fits    = trial >= {1'b0, prod_ff};

   // mix arithmetic
   logic signed [8:0]  diff_s;
   logic signed [8:0]  vol_s;
   logic signed [17:0] mix_prod;
   logic signed [SUM_BITS-1:0] half;
   assign diff_s   = $signed({1'b0, rd_byte_ff}) - $signed({1'b0, SAMPLE_BIAS});
   assign vol_s    = $signed({1'b0, vol_ff[cmd.ch]});
   assign mix_prod = diff_s * vol_s;
   assign half     = (sum_ff + $signed({{(SUM_BITS-1){1'b0}}, sum_ff[SUM_BITS-1]})) >>> 1;

   logic [3:0] sel;
   logic [CH_BITS-1:0] d_ch, bl_ch;
   assign sel   = low_ff[3:0];
   assign d_ch  = data_ff[1:0];
   assign bl_ch = low_ff[2:1];

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff   <= req_command;
         unit_ff  <= req_port_unit;
         low_ff   <= req_port_low;
         data_ff  <= req_write_data;
         laddr_ff <= req_load_address;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_BITS'(rate_ff) * PROD_BITS'(timer_ff[tch_ff]);
         rem_ff  <= '0;
         quo_ff  <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= fits ? PROD_BITS'(trial - {1'b0, prod_ff}) : PROD_BITS'(trial);
         quo_ff <= {quo_ff[NUM_BITS-2:0], fits};
      end
      if (cmd.mix) ptr_next_ff <= ptr_ff[cmd.ch] + step_ff[cmd.ch];
      if (cmd.load_rsp) begin
         rsp_read_ff   <= rd_ff;
         rsp_sample_ff <= 17'(half);
         rsp_nmi_ff    <= nmi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff     <= RATE_RESET;
         loop_ff     <= '0;
         mask_ff     <= '1;
         done_ff     <= '0;
         tch_ff      <= '0;
         cnt_ff      <= '0;
         sum_ff      <= '0;
         nmi_ff      <= 1'b0;
         rd_ff       <= READ_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            begin_ff[i] <= '0;
            len_ff[i]   <= '0;
            ptr_ff[i]   <= '0;
            end_ff[i]   <= '0;
            step_ff[i]  <= '0;
            timer_ff[i] <= '0;
            vol_ff[i]   <= '0;
         end
         for (int i = 0; i < 16; i++) page_ff[i] <= '0;
      end else begin
         if (csr_valid) rate_ff <= csr_data;
         if (cmd.latch) begin
            sum_ff      <= '0;
            nmi_ff      <= 1'b0;
            rd_ff       <= READ_IDLE;
         end
         if (cmd.exec) begin
            unique case (command_type'(cmd_ff))
               CMD_WRITE: begin
                  unique case (unit_type'(unit_ff))
                     UNIT_DMA: begin
                        priority if (sel == DMA_STATUS || sel == DMA_IGNORED) begin
                        end else if (sel == DMA_LOOP) begin
                           loop_ff[d_ch] <= data_ff[4];
                        end else if (sel == DMA_CONTROL) begin
                           if (data_ff[2]) begin
                              mask_ff[d_ch] <= 1'b1;
                           end else begin
                              ptr_ff[d_ch]  <= begin_ff[d_ch];
                              end_ff[d_ch]  <= begin_ff[d_ch] + len_ff[d_ch];
                              mask_ff[d_ch] <= 1'b0;
                           end
                        end else if (low_ff[0]) begin
                           len_ff[bl_ch] <= {data_ff, len_ff[bl_ch][31:24], 16'h0000};
                        end else begin
                           begin_ff[bl_ch] <= {data_ff, begin_ff[bl_ch][31:24], 16'h0000};
                        end
                     end
                     UNIT_TIMER: begin
                        if (t_ok) begin
                           timer_ff[t_ch] <= {data_ff, timer_ff[t_ch][15:8]};
                           tch_ff         <= t_ch;
                        end
                     end
                     UNIT_VOLUME: vol_ff[low_ff[1:0]] <= data_ff;
                     UNIT_MAPPER: page_ff[{low_ff[3:2], low_ff[1:0]}] <= ~data_ff[4:0];
                     default: ;
                  endcase
               end
               CMD_READ: begin
                  if (unit_type'(unit_ff) == UNIT_DMA && sel == DMA_STATUS) begin
                     rd_ff   <= {4'h0, done_ff};
                     done_ff <= '0;
                  end
               end
               CMD_TICK: ;
               CMD_LOAD: ;
               default: ;
            endcase
         end
         if (cmd.mul) cnt_ff <= '0;
         if (cmd.div_step) cnt_ff <= cnt_ff + 1'b1;
         if (cmd.step_wr) begin
            if (prod_ff == '0 || quo_ff[NUM_BITS-1:32] != '0) step_ff[tch_ff] <= STEP_SAT;
            else step_ff[tch_ff] <= quo_ff[31:0];
         end
         if (cmd.mix) sum_ff <= sum_ff + SUM_BITS'(mix_prod);
         if (cmd.wrap) begin
            ptr_ff[cmd.ch] <= ptr_next_ff;
            if (ptr_next_ff >= end_ff[cmd.ch]) begin
               if (loop_ff[cmd.ch]) begin
                  ptr_ff[cmd.ch] <= ptr_next_ff - len_ff[cmd.ch];
               end else begin
                  done_ff[cmd.ch] <= 1'b1;
                  mask_ff[cmd.ch] <= 1'b1;
                  nmi_ff          <= 1'b1;
               end
            end
         end
         if (cmd.load_rsp)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready)     rsp_valid_ff <= 1'b0;
      end
   end

   assign status.is_tick  = (command_type'(cmd_ff) == CMD_TICK);
   // decoded from the latched word while the controller executes it
   assign status.need_div = (command_type'(cmd_ff) == CMD_WRITE) &&
                            (unit_type'(unit_ff) == UNIT_TIMER) && t_ok;
   assign status.active   = ~(mask_ff | done_ff);
   assign status.div_last = (cnt_ff == CNT_BITS'(NUM_BITS-1));
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_read_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_nmi_pulse  = rsp_nmi_ff;

endmodule

// ===== rtl/four_channel_dma_sample_mixer.sv =====
// Register read/write and memory load pass the execute and finish states.
// Valid timer write: adds one multiply and a 38-step restoring divider for the step.
// Tick: address, mix and wrap states per active channel; address only per silent one.
// One word at a time; the next word is taken while the last result waits.
// Reset (synchronous, active high): all channels stopped, registers and status
// cleared, rate 44100; the sample store is not cleared.
module four_channel_dma_sample_mixer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [1:0]         req_port_unit,
   input  logic [7:0]         req_port_low,
   input  logic [7:0]         req_write_data,
   input  logic [18:0]        req_load_address,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [17:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_read_data,
   output logic signed [16:0] rsp_sample_out,
   output logic               rsp_nmi_pulse
);
   import fcdsm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   fcdsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fcdsm_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_command      (req_command),
      .req_port_unit    (req_port_unit),
      .req_port_low     (req_port_low),
      .req_write_data   (req_write_data),
      .req_load_address (req_load_address),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_nmi_pulse    (rsp_nmi_pulse)
   );

endmodule

// ===== rtl/fcdsm_checker.sv =====
module fcdsm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [7:0]         rsp_read_data,
   input logic signed [16:0] rsp_sample_out,
   input logic               rsp_nmi_pulse
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_nmi_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_nmi_pulse |-> rsp_read_data == 8'hFF)
      else $error("nmi on a status read");

   a_sample_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_out != 17'sd0 |-> rsp_read_data == 8'hFF)
      else $error("sample on a status read");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind four_channel_dma_sample_mixer fcdsm_checker u_fcdsm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_data  (rsp_read_data),
   .rsp_sample_out (rsp_sample_out),
   .rsp_nmi_pulse  (rsp_nmi_pulse)
);
